// ===== src/rfd_pkg.sv =====
// rx frame deframer package: parse phases, event codes, register indexes
// and the structs passed between the deframer modules. no dependencies.
`default_nettype none

package rfd_pkg;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_TYPE = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_CSUM = 3'd4,
      PH_END  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PAYLOAD = 3'd1,
      EV_ACCEPT  = 3'd2,
      EV_CSUMERR = 3'd3,
      EV_ENDERR  = 3'd4
   } event_type;

   localparam int CsrIndexWidth = 8;

   localparam logic [CsrIndexWidth-1:0] REG_START_MARKER = 8'd0;
   localparam logic [CsrIndexWidth-1:0] REG_END_MARKER   = 8'd1;

   localparam logic [7:0] START_MARKER_RESET = 8'd170;
   localparam logic [7:0] END_MARKER_RESET   = 8'd85;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
   } cfg_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [7:0]  frame_type;
      logic [7:0]  frame_length;
      logic [15:0] bad_frames;
   } result_type;

endpackage

`default_nettype wire

// ===== src/rfd_csr.sv =====
// configuration registers for the rx frame deframer: start and end markers
// depends on rfd_pkg
`default_nettype none

module rfd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rfd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [7:0]                         csr_wdata,
   output rfd_pkg::cfg_type                        cfg
);
   import rfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_START_MARKER: cfg_in.start_marker = csr_wdata;
            REG_END_MARKER:   cfg_in.end_marker   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= START_MARKER_RESET;
         cfg_ff.end_marker   <= END_MARKER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rfd_parser.sv =====
// frame parser state and per-byte update: phase, held type and length,
// payload count, running xor and reject counter. depends on rfd_pkg
`default_nettype none

module rfd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   input  wire rfd_pkg::cfg_type  cfg,
   output rfd_pkg::result_type    res
);
   import rfd_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [7:0]  type_ff,    type_in;
   logic [7:0]  length_ff,  length_in;
   logic [7:0]  count_ff,   count_in;
   logic [7:0]  xor_ff,     xor_in;
   logic [15:0] reject_ff,  reject_in;
   event_type   ev;
   logic [7:0]  data;
   logic [7:0]  idx;

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      length_in = length_ff;
      count_in  = count_ff;
      xor_in    = xor_ff;
      reject_in = reject_ff;
      ev        = EV_NONE;
      data      = 8'd0;
      idx       = 8'd0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.start_marker) begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_in  = rx_byte;
            xor_in   = rx_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            length_in = rx_byte;
            xor_in    = xor_ff ^ rx_byte;
            count_in  = 8'd0;
            phase_in  = (rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
         end
         PH_DATA: begin
            ev       = EV_PAYLOAD;
            data     = rx_byte;
            idx      = count_ff;
            xor_in   = xor_ff ^ rx_byte;
            count_in = count_ff + 8'd1;
            if (count_in >= length_ff) begin
               phase_in = PH_CSUM;
            end
         end
         PH_CSUM: begin
            if (rx_byte == xor_ff) begin
               phase_in = PH_END;
            end else begin
               ev        = EV_CSUMERR;
               reject_in = reject_ff + 16'd1;
               phase_in  = PH_HUNT;
            end
         end
         PH_END: begin
            phase_in = PH_HUNT;
            if (rx_byte == cfg.end_marker) begin
               ev = EV_ACCEPT;
            end else begin
               ev        = EV_ENDERR;
               reject_in = reject_ff + 16'd1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   assign res.event_res    = ev;
   assign res.data_byte    = data;
   assign res.byte_index   = idx;
   assign res.frame_type   = type_in;
   assign res.frame_length = length_in;
   assign res.bad_frames   = reject_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         type_ff   <= 8'd0;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         xor_ff    <= 8'd0;
         reject_ff <= 16'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         xor_ff    <= xor_in;
         reject_ff <= reject_in;
      end
   end

   // payload index always stays inside the announced length
   assert property (@(posedge clock) disable iff (reset)
      step && (ev == EV_PAYLOAD) |-> (idx < length_ff))
      else $error("payload index beyond frame length");

   // any error sends the parser back to hunting and bumps the counter
   assert property (@(posedge clock) disable iff (reset)
      step && ((ev == EV_CSUMERR) || (ev == EV_ENDERR))
      |=> (phase_ff == PH_HUNT) && (reject_ff == $past(reject_ff) + 16'd1))
      else $error("error did not restart hunt or count");

   // without an item the parser state holds
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(reject_ff) && $stable(xor_ff))
      else $error("parser state moved without an item");

   // an accepted frame only comes out of the end-marker phase
   assert property (@(posedge clock) disable iff (reset)
      step && (ev == EV_ACCEPT) |-> (phase_ff == PH_END) && (rx_byte == cfg.end_marker))
      else $error("frame accepted outside end-marker phase");

endmodule

`default_nettype wire

// ===== src/rx_frame_deframer_xor.sv =====
// rx frame deframer top level: input register, parser and result register
// depends on rfd_pkg, rfd_csr, rfd_parser
//
// usage:
//   req_ channel carries one received byte per item (req_rx_byte).
//   rsp_ channel returns exactly one result item per input item: event
//   code, payload byte and index, current type and length, and the
//   wrapping bad-frame count.
//   csr_ channel writes the start marker (index 0) or end marker
//   (index 1); other indexes are ignored. write only while idle.
// path: an accepted byte is held in the input register; the parser update
//   loads the result register once it is empty or its result is taken.
// throughput: one item per cycle while rsp_ready is high; the parser state
//   update is one compare, xor and increment between the two registers.
// reset: parser returns to hunting for the start marker, counters and
//   held fields clear, markers return to 170 and 85, no item in flight.
// stall: while rsp_ready is low the result holds; the input register still
//   takes one more item, after which req_ready drops until the result
//   moves on.
`default_nettype none

module rx_frame_deframer_xor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [2:0]                              rsp_event_res,
   output logic [7:0]                              rsp_data_byte,
   output logic [7:0]                              rsp_byte_index,
   output logic [7:0]                              rsp_frame_type,
   output logic [7:0]                              rsp_frame_length,
   output logic [15:0]                             rsp_bad_frames,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rfd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [7:0]                         csr_wdata
);
   import rfd_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type res_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       take;

   rfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .res     (res)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in  = take ? 1'b1 : (in_valid_ff && !advance);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = res_ff.event_res;
   assign rsp_data_byte    = res_ff.data_byte;
   assign rsp_byte_index   = res_ff.byte_index;
   assign rsp_frame_type   = res_ff.frame_type;
   assign rsp_frame_length = res_ff.frame_length;
   assign rsp_bad_frames   = res_ff.bad_frames;

endmodule

`default_nettype wire
